>>> rtl/reno_congestion_window_unit_assert.svh
// ----------------------------------------------------------------------------
// reno congestion window unit assertion macros
// shared concurrent assertion forms for the rtl of the unit
// ----------------------------------------------------------------------------
`ifndef RENO_CONGESTION_WINDOW_UNIT_ASSERT_SVH
`define RENO_CONGESTION_WINDOW_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RCW_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcw implication check failed");

// antecedent implies consequent in the next cycle
`define RCW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcw next cycle check failed");

// condition never holds
`define RCW_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rcw forbidden condition seen");

`endif

>>> rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// types and constants of the reno congestion window unit
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_SLOW_START    = 2'd0,
      PHASE_CONG_AVOID    = 2'd1,
      PHASE_FAST_RECOVERY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_EXEC,
      ENG_FR_LOAD,
      ENG_MUL,
      ENG_DIV_LOAD,
      ENG_DIV,
      ENG_REPORT
   } eng_state_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // register indexes
   localparam logic CSR_SEG_SIZE     = 1'b0;
   localparam logic CSR_START_THRESH = 1'b1;

   localparam logic [15:0] SEG_SIZE_RESET     = 16'd1024;
   localparam logic [23:0] START_THRESH_RESET = 24'd65535;
   localparam logic [15:0] PEER_WINDOW_RESET  = 16'hFFFF;
   localparam logic [23:0] MAX24              = 24'hFFFFFF;
   localparam logic [2:0]  DUP_FAST_RETX      = 3'd3;
   localparam logic [2:0]  DUP_SAT            = 3'd4;
   localparam logic [17:0] FR_INFLATE_SEGS    = 18'd3;

   typedef struct packed {
      logic [15:0] seg_size;
      logic [23:0] start_threshold;
   } rcw_cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] ack_seq;
      logic [15:0] adv_window;
   } rcw_req_type;

   typedef struct packed {
      logic [23:0] window_bytes;
      logic [23:0] threshold_bytes;
      phase_type   phase;
      logic [23:0] usable_window;
      logic        retransmit;
      logic [15:0] retransmit_seq;
      logic [15:0] bytes_acked;
      logic        flush_flight;
   } rcw_rsp_type;

endpackage

`default_nettype wire

>>> rtl/rcw_divider.sv
// ----------------------------------------------------------------------------
// rcw_divider
// shift register restoring divider, one quotient bit per cycle, with the
// quotient saturated to the divisor width
// ----------------------------------------------------------------------------
`default_nettype none

`include "reno_congestion_window_unit_assert.svh"

module rcw_divider #(
   parameter int DIV_BITS = 32,
   parameter int NUM_BITS = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numerator,
   input  wire logic [DIV_BITS-1:0] divisor,
   output logic                     done,
   output logic [DIV_BITS-1:0]      quotient
);
   import rcw_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS);

   div_state_type         state_ff, state_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   shq_ff, shq_in;
   logic [DIV_BITS-1:0]   divisor_ff, divisor_in;
   logic [NUM_BITS-1:0]   num_high;
   logic [DIV_BITS:0]     trial;
   logic [DIV_BITS:0]     trial_diff;
   logic                  trial_ge;

   assign num_high   = numerator >> DIV_BITS;
   assign trial      = {rem_ff, shq_ff[DIV_BITS-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge   = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      shq_ff     <= shq_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      shq_in     = shq_ff;
      divisor_in = divisor_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               divisor_in = divisor;
               // quotient does not fit: saturate
               if (num_high >= NUM_BITS'(divisor)) begin
                  shq_in  = {DIV_BITS{1'b1}};
                  done_in = 1'b1;
               end else begin
                  rem_in   = DIV_BITS'(num_high);
                  shq_in   = numerator[DIV_BITS-1:0];
                  cnt_in   = CNT_BITS'(DIV_BITS - 1);
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in = trial_ge ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            shq_in = {shq_ff[DIV_BITS-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign done     = done_ff;
   assign quotient = shq_ff;

   `RCW_ASSERT_NEVER(a_start_while_busy, clock, reset, start && state_ff == DIV_RUN)
   `RCW_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, state_ff == DIV_RUN, rem_ff < divisor_ff)
   `RCW_ASSERT_IMPLIES(a_done_when_idle, clock, reset, done_ff, state_ff == DIV_IDLE)

endmodule

`default_nettype wire

>>> rtl/rcw_engine.sv
// ----------------------------------------------------------------------------
// rcw_engine
// reno congestion state and event sequencer, drives the serial divider for
// congestion avoidance growth
// ----------------------------------------------------------------------------
`default_nettype none

`include "reno_congestion_window_unit_assert.svh"

module rcw_engine #(
   parameter int WIN_INT_BITS  = 24,
   parameter int WIN_FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rcw_pkg::rcw_cfg_type cfg,
   input  wire logic                 req_valid,
   input  wire rcw_pkg::rcw_req_type req,
   output logic                      req_ready,
   output logic                      rsp_valid,
   output rcw_pkg::rcw_rsp_type      rsp,
   input  wire logic                 rsp_ready
);
   import rcw_pkg::*;

   localparam int W        = WIN_INT_BITS + WIN_FRAC_BITS;
   localparam int NUM_BITS = 32 + 2 * WIN_FRAC_BITS;

   function automatic logic [W-1:0] to_fixed(input logic [23:0] bytes);
      logic [31:0]              ext;
      logic [31+WIN_FRAC_BITS:0] wide;
      ext  = 32'(bytes);
      wide = {ext, {WIN_FRAC_BITS{1'b0}}};
      if ((ext >> WIN_INT_BITS) != 32'd0) return {W{1'b1}};
      return wide[W-1:0];
   endfunction

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[W] ? {W{1'b1}} : s[W-1:0];
   endfunction

   function automatic logic [23:0] halved(input logic [W-1:0] win, input logic [15:0] seg);
      logic [47:0] h;
      h = 48'(win >> (WIN_FRAC_BITS + 1));
      if (h < 48'(seg)) h = 48'(seg);
      if (h > 48'(MAX24)) h = 48'(MAX24);
      return h[23:0];
   endfunction

   eng_state_type state_ff, state_in;
   rcw_req_type   req_ff, req_in;
   logic [W-1:0]  cw_ff, cw_in;
   logic [23:0]   thr_ff, thr_in;
   phase_type     phase_ff, phase_in;
   logic [15:0]   last_ack_ff, last_ack_in;
   logic [2:0]    dup_ff, dup_in;
   logic [15:0]   peer_ff, peer_in;
   logic          retx_ff, retx_in;
   logic [15:0]   retx_seq_ff, retx_seq_in;
   logic [15:0]   acked_ff, acked_in;
   logic          flush_ff, flush_in;
   logic [31:0]   sq_ff, sq_in;

   logic [2:0]    dup_inc;
   logic [W-1:0]  seg_fixed;
   logic [W-1:0]  grown;
   logic [17:0]   seg3;
   logic          div_start;
   logic          div_done;
   logic [W-1:0]  div_quotient;
   logic [47:0]   wint_wide;
   logic [23:0]   wint;

   assign dup_inc   = (dup_ff < DUP_SAT) ? dup_ff + 3'd1 : dup_ff;
   assign seg_fixed = to_fixed(24'(cfg.seg_size));
   assign grown     = sat_add(cw_ff, seg_fixed);
   assign seg3      = 18'(cfg.seg_size) * FR_INFLATE_SEGS;
   assign div_start = state_ff == ENG_DIV_LOAD;

   rcw_divider #(
      .DIV_BITS (W),
      .NUM_BITS (NUM_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator ({sq_ff, {(2 * WIN_FRAC_BITS){1'b0}}}),
      .divisor   (cw_ff),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         cw_ff       <= to_fixed(24'(SEG_SIZE_RESET));
         thr_ff      <= START_THRESH_RESET;
         phase_ff    <= PHASE_SLOW_START;
         last_ack_ff <= '0;
         dup_ff      <= '0;
         peer_ff     <= PEER_WINDOW_RESET;
      end else begin
         state_ff    <= state_in;
         cw_ff       <= cw_in;
         thr_ff      <= thr_in;
         phase_ff    <= phase_in;
         last_ack_ff <= last_ack_in;
         dup_ff      <= dup_in;
         peer_ff     <= peer_in;
      end
      req_ff      <= req_in;
      retx_ff     <= retx_in;
      retx_seq_ff <= retx_seq_in;
      acked_ff    <= acked_in;
      flush_ff    <= flush_in;
      sq_ff       <= sq_in;
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cw_in       = cw_ff;
      thr_in      = thr_ff;
      phase_in    = phase_ff;
      last_ack_in = last_ack_ff;
      dup_in      = dup_ff;
      peer_in     = peer_ff;
      retx_in     = retx_ff;
      retx_seq_in = retx_seq_ff;
      acked_in    = acked_ff;
      flush_in    = flush_ff;
      sq_in       = sq_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req;
               state_in = ENG_EXEC;
            end
         end
         ENG_EXEC: begin
            retx_in     = 1'b0;
            retx_seq_in = '0;
            acked_in    = '0;
            flush_in    = 1'b0;
            state_in    = ENG_REPORT;
            case (req_ff.cmd)
               CMD_START: begin
                  cw_in       = seg_fixed;
                  thr_in      = cfg.start_threshold;
                  phase_in    = PHASE_SLOW_START;
                  last_ack_in = req_ff.ack_seq;
                  dup_in      = '0;
                  peer_in     = req_ff.adv_window;
               end
               CMD_ACK: begin
                  peer_in = req_ff.adv_window;
                  if (req_ff.ack_seq == last_ack_ff) begin
                     dup_in = dup_inc;
                     if (dup_inc == DUP_FAST_RETX) begin
                        thr_in      = halved(cw_ff, cfg.seg_size);
                        phase_in    = PHASE_FAST_RECOVERY;
                        retx_in     = 1'b1;
                        retx_seq_in = req_ff.ack_seq;
                        state_in    = ENG_FR_LOAD;
                     end else if (dup_inc > DUP_FAST_RETX &&
                                  phase_ff == PHASE_FAST_RECOVERY) begin
                        cw_in = grown;
                     end
                  end else if (req_ff.ack_seq > last_ack_ff) begin
                     acked_in    = req_ff.ack_seq - last_ack_ff;
                     last_ack_in = req_ff.ack_seq;
                     dup_in      = '0;
                     case (phase_ff)
                        PHASE_SLOW_START: begin
                           cw_in = grown;
                           if (grown >= to_fixed(thr_ff)) phase_in = PHASE_CONG_AVOID;
                        end
                        PHASE_CONG_AVOID: begin
                           state_in = ENG_MUL;
                        end
                        default: begin
                           cw_in    = to_fixed(thr_ff);
                           phase_in = PHASE_CONG_AVOID;
                        end
                     endcase
                  end
               end
               CMD_TIMEOUT: begin
                  thr_in   = halved(cw_ff, cfg.seg_size);
                  cw_in    = seg_fixed;
                  phase_in = PHASE_SLOW_START;
                  dup_in   = '0;
                  flush_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ENG_FR_LOAD: begin
            cw_in    = sat_add(to_fixed(thr_ff), to_fixed(24'(seg3)));
            state_in = ENG_REPORT;
         end
         ENG_MUL: begin
            sq_in    = 32'(cfg.seg_size) * 32'(cfg.seg_size);
            state_in = ENG_DIV_LOAD;
         end
         ENG_DIV_LOAD: begin
            state_in = ENG_DIV;
         end
         ENG_DIV: begin
            if (div_done) begin
               cw_in    = sat_add(cw_ff, div_quotient);
               state_in = ENG_REPORT;
            end
         end
         ENG_REPORT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ENG_IDLE;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign wint_wide = 48'(cw_ff >> WIN_FRAC_BITS);
   assign wint      = (wint_wide > 48'(MAX24)) ? MAX24 : wint_wide[23:0];

   always_comb begin
      rsp.window_bytes    = wint;
      rsp.threshold_bytes = thr_ff;
      rsp.phase           = phase_ff;
      rsp.usable_window   = (wint < 24'(peer_ff)) ? wint : 24'(peer_ff);
      rsp.retransmit      = retx_ff;
      rsp.retransmit_seq  = retx_seq_ff;
      rsp.bytes_acked     = acked_ff;
      rsp.flush_flight    = flush_ff;
   end

   `RCW_ASSERT_NEVER(a_dup_saturates, clock, reset, dup_ff > DUP_SAT)
   `RCW_ASSERT_IMPLIES(a_div_done_in_div, clock, reset, div_done, state_ff == ENG_DIV)
   `RCW_ASSERT_IMPLIES(a_retx_in_recovery, clock, reset, state_ff == ENG_REPORT && retx_ff, phase_ff == PHASE_FAST_RECOVERY)
   `RCW_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_valid && req_ready, state_ff == ENG_EXEC)

endmodule

`default_nettype wire

>>> rtl/reno_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// reno_congestion_window_unit
// reno congestion window controller with a serial divider for growth in
// congestion avoidance
//
// requests arrive on req_ (tuser the event kind, tdata ack number and
// advertised window); each request yields exactly one response on rsp_.
// registers seg_size and start_threshold are written on csr_; the user must
// write them only while idle, the unit does not enforce it. a request runs
// from acceptance through states exec and report; the third duplicate ack
// adds fr_load; a new ack in congestion avoidance adds mul, div_load and div,
// where the divider of seg_size squared by the window yields one quotient
// bit per cycle or skips its bit loop when the quotient saturates. the
// response enters rsp_ registers as the engine goes idle, before acceptance.
// one request is worked on at a time; an output register holds the last
// response, so a new request is taken while it waits. when the receiver
// stalls and the output register is full, the finished response waits in
// the engine and req_tready stays low.
// synchronous reset loads seg_size 1024, start_threshold 65535, a window
// of one segment in slow start and clears the output register's valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module reno_congestion_window_unit #(
   parameter int WIN_INT_BITS  = 24,
   parameter int WIN_FRAC_BITS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,  // ack_seq, adv_window
   input  wire logic [1:0]   req_tuser,  // cmd
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // window_bytes, threshold_bytes, phase, usable_window, retransmit,
   // retransmit_seq, bytes_acked, flush_flight, zero pad
   output logic [111:0]      rsp_tdata,
   // configuration
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [23:0]  csr_wdata
);
   import rcw_pkg::*;

   logic [15:0]  seg_size_ff;
   logic [23:0]  start_thresh_ff;
   rcw_cfg_type  cfg;
   rcw_req_type  req;
   logic         eng_rsp_valid;
   logic         eng_rsp_ready;
   rcw_rsp_type  eng_rsp;
   logic         rsp_valid_ff;
   rcw_rsp_type  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_size_ff     <= SEG_SIZE_RESET;
         start_thresh_ff <= START_THRESH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEG_SIZE:     seg_size_ff     <= csr_wdata[15:0];
            CSR_START_THRESH: start_thresh_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.seg_size        = seg_size_ff;
   assign cfg.start_threshold = start_thresh_ff;

   assign req.cmd        = cmd_type'(req_tuser);
   assign req.ack_seq    = req_tdata[15:0];
   assign req.adv_window = req_tdata[31:16];

   rcw_engine #(
      .WIN_INT_BITS  (WIN_INT_BITS),
      .WIN_FRAC_BITS (WIN_FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .rsp_valid (eng_rsp_valid),
      .rsp       (eng_rsp),
      .rsp_ready (eng_rsp_ready)
   );

   // output register
   assign eng_rsp_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_rsp_ready) begin
         rsp_valid_ff <= eng_rsp_valid;
      end
      if (eng_rsp_ready && eng_rsp_valid) rsp_data_ff <= eng_rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.flush_flight,
                        rsp_data_ff.bytes_acked,
                        rsp_data_ff.retransmit_seq,
                        rsp_data_ff.retransmit,
                        rsp_data_ff.usable_window,
                        rsp_data_ff.phase,
                        rsp_data_ff.threshold_bytes,
                        rsp_data_ff.window_bytes};

endmodule

`default_nettype wire
